// File: design/mrgic_pkg.sv
`timescale 1ns / 1ps
package mrgic_pkg;

    localparam int NUM_AX    = 6;
    localparam int LIN_W     = 48;
    localparam int IDX_W     = 8;
    localparam int SIZE_W    = 9;
    localparam int OP_W      = 3;
    localparam int CHUNK_W   = 8;
    localparam int NUM_CHUNK = LIN_W / CHUNK_W;
    localparam int NUM_STAGE = NUM_AX * NUM_CHUNK;
    localparam int ADDR_W    = 3;
    localparam int MAX_AXIS_SIZE_DEF = 256;

    localparam logic [OP_W-1:0] OP_COMPOSE5       = 3'd0;
    localparam logic [OP_W-1:0] OP_COMPOSE6       = 3'd1;
    localparam logic [OP_W-1:0] OP_CELL_COMPOSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_DECOMPOSE5     = 3'd3;
    localparam logic [OP_W-1:0] OP_DECOMPOSE6     = 3'd4;
    localparam logic [OP_W-1:0] OP_CELL_DECOMPOSE = 3'd5;

    localparam int AX_X    = 0;
    localparam int AX_Y    = 1;
    localparam int AX_PSI  = 2;
    localparam int AX_PHI0 = 3;
    localparam int AX_R    = 4;
    localparam int AX_PHI1 = 5;

    typedef logic [NUM_AX-1:0][SIZE_W-1:0] sizes_t;
    typedef logic [NUM_AX-1:0][IDX_W-1:0]  idx_vec_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [LIN_W-1:0]  lin;
        logic [SIZE_W-1:0] rem;
        idx_vec_t          idx_in;
        idx_vec_t          idx_out;
        logic [LIN_W-1:0]  acc;
        logic              cok;
    } beat_t;

    function automatic logic is_compose(input logic [OP_W-1:0] op);
        return (op == OP_COMPOSE5) || (op == OP_COMPOSE6) || (op == OP_CELL_COMPOSE);
    endfunction

    function automatic logic is_decompose(input logic [OP_W-1:0] op);
        return (op == OP_DECOMPOSE5) || (op == OP_DECOMPOSE6) || (op == OP_CELL_DECOMPOSE);
    endfunction

    function automatic logic axis_used(input logic [OP_W-1:0] op, input int ax);
        logic u;
        unique case (op) inside
            OP_COMPOSE5, OP_DECOMPOSE5:         u = (ax <= AX_R);
            OP_COMPOSE6, OP_DECOMPOSE6:         u = 1'b1;
            OP_CELL_COMPOSE, OP_CELL_DECOMPOSE: u = (ax >= AX_PSI) && (ax <= AX_R);
            default:                            u = 1'b0;
        endcase
        return u;
    endfunction

endpackage

// File: design/mrgic_cfg.sv
`timescale 1ns / 1ps
module mrgic_cfg
    import mrgic_pkg::*;
#(
    parameter int MAX_AXIS_SIZE = MAX_AXIS_SIZE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_wdata,
    output sizes_t            sizes
);

    sizes_t            sizes_reg;
    logic [SIZE_W-1:0] clamp_next;

    always_comb begin
        if (cfg_wdata == '0) begin
            clamp_next = SIZE_W'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_AXIS_SIZE)) begin
            clamp_next = SIZE_W'(MAX_AXIS_SIZE);
        end else begin
            clamp_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AX; i++) sizes_reg[i] <= SIZE_W'(1);
        end else if (cfg_wr_en && (32'(cfg_index) < 32'(NUM_AX))) begin
            sizes_reg[cfg_index] <= clamp_next;
        end
    end

    assign sizes = sizes_reg;

endmodule

// File: design/mrgic_stage.sv
`timescale 1ns / 1ps
module mrgic_stage
    import mrgic_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  sizes_t sizes,
    input  logic   in_valid,
    output logic   in_ready,
    input  beat_t  in_beat,
    output logic   out_valid,
    input  logic   out_ready,
    output beat_t  out_beat
);

    localparam int SLOT  = STAGE / NUM_CHUNK;
    localparam int CHUNK = STAGE % NUM_CHUNK;
    localparam int DAX   = NUM_AX - 1 - SLOT;
    localparam int CAX   = SLOT;
    localparam int TOP   = LIN_W - 1 - CHUNK * CHUNK_W;
    localparam int PW    = LIN_W + SIZE_W;

    logic              valid_reg;
    beat_t             beat_reg;
    beat_t             beat_next;

    always_comb begin
        logic [SIZE_W-1:0] d;
        logic [SIZE_W-1:0] r;
        logic [SIZE_W:0]   t;
        logic [SIZE_W-1:0] cs;
        logic [PW-1:0]     prod;
        beat_next = in_beat;
        d = (is_decompose(in_beat.op) && axis_used(in_beat.op, DAX)) ?
            sizes[DAX] : SIZE_W'(1);
        r = (CHUNK == 0) ? '0 : in_beat.rem;
        for (int i = 0; i < CHUNK_W; i++) begin
            t = {r, in_beat.lin[TOP - i]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                beat_next.lin[TOP - i] = 1'b1;
            end else begin
                beat_next.lin[TOP - i] = 1'b0;
            end
            r = t[SIZE_W-1:0];
        end
        beat_next.rem = r;
        if (CHUNK == NUM_CHUNK - 1) beat_next.idx_out[DAX] = r[IDX_W-1:0];

        cs = sizes[CAX];
        prod = PW'(in_beat.acc) * PW'(cs) + PW'(in_beat.idx_in[CAX]);
        if ((CHUNK == 0) && is_compose(in_beat.op) && axis_used(in_beat.op, CAX)) begin
            if ((SIZE_W'(in_beat.idx_in[CAX]) >= cs) || (prod[PW-1:LIN_W] != '0)) begin
                beat_next.cok = 1'b0;
            end
            beat_next.acc = prod[LIN_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: design/mixed_radix_grid_index_converter.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: index beat, tuser: operation
// m_axis    out        m_axis_tvalid/tready       tdata: result beat, tuser: ok
// cfg       in         cfg_wr_en                  cfg_index, cfg_wdata: axis size
//
// One beat a cycle while m_axis accepts; the pipe has six axes times six stages,
// each stage resolving eight quotient bits of one 48-bit division.
// Reset clears the valid bits and sets every axis size to 1.
// Stages collapse bubbles; a stall on m_axis backs up stage by stage.
module mixed_radix_grid_index_converter
    import mrgic_pkg::*;
#(
    parameter int MAX_AXIS_SIZE = MAX_AXIS_SIZE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // linear_in[47:0], x_in, y_in, psi_in, phi0_in, r_in, phi1_in (8 each)
    input  logic [95:0]       s_axis_tdata,
    // operation[2:0]
    input  logic [OP_W-1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // linear_out[47:0], x_out, y_out, psi_out, phi0_out, r_out, phi1_out (8 each)
    output logic [95:0]       m_axis_tdata,
    // ok
    output logic [0:0]        m_axis_tuser,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    sizes_t cfg_sizes;
    logic   vld   [NUM_STAGE+1];
    logic   rdy   [NUM_STAGE+1];
    beat_t  beats [NUM_STAGE+1];
    beat_t  last_beat;
    logic   ok;

    mrgic_cfg #(.MAX_AXIS_SIZE(MAX_AXIS_SIZE)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sizes     (cfg_sizes)
    );

    always_comb begin
        beats[0].op      = s_axis_tuser;
        beats[0].lin     = s_axis_tdata[LIN_W-1:0];
        beats[0].rem     = '0;
        beats[0].idx_in  = idx_vec_t'(s_axis_tdata[LIN_W +: NUM_AX*IDX_W]);
        beats[0].idx_out = '0;
        beats[0].acc     = '0;
        beats[0].cok     = 1'b1;
    end

    assign vld[0]        = s_axis_tvalid;
    assign s_axis_tready = rdy[0];

    for (genvar s = 0; s < NUM_STAGE; s++) begin : g_stage
        mrgic_stage #(.STAGE(s)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .sizes     (cfg_sizes),
            .in_valid  (vld[s]),
            .in_ready  (rdy[s]),
            .in_beat   (beats[s]),
            .out_valid (vld[s+1]),
            .out_ready (rdy[s+1]),
            .out_beat  (beats[s+1])
        );
    end

    assign rdy[NUM_STAGE] = m_axis_tready;
    assign last_beat      = beats[NUM_STAGE];

    always_comb begin
        if (is_compose(last_beat.op)) begin
            ok = last_beat.cok;
        end else if (is_decompose(last_beat.op)) begin
            ok = (last_beat.lin == '0);
        end else begin
            ok = 1'b0;
        end
    end

    assign m_axis_tvalid = vld[NUM_STAGE];
    assign m_axis_tuser  = ok;
    assign m_axis_tdata  = {last_beat.idx_out,
                            (is_compose(last_beat.op) && last_beat.cok) ?
                                last_beat.acc : {LIN_W{1'b0}}};

    a_sizes_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_sizes[0] != '0 && cfg_sizes[1] != '0 && cfg_sizes[2] != '0 &&
        cfg_sizes[3] != '0 && cfg_sizes[4] != '0 && cfg_sizes[5] != '0)
        else $error("axis size register holds zero");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_decomp_lin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && is_decompose(last_beat.op) |-> m_axis_tdata[LIN_W-1:0] == '0)
        else $error("decompose beat carries a linear index");

    a_fail_lin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[LIN_W-1:0] == '0)
        else $error("failed beat carries a linear index");

endmodule
